[rtl/imu_sbc_pkg.sv]
// Shared types and constants for the IMU still-bias calibration block.
package imu_sbc_pkg;

    localparam int SAMPLE_W  = 16;
    localparam int THRESH_W  = 16;
    localparam int NEEDED_W  = 8;
    localparam int GRAV_W    = 15;
    localparam int CFG_W     = 16;
    localparam int CFG_IDX_W = 2;
    localparam int NUM_AXES  = 6;
    localparam int NUM_GYRO  = 3;

    localparam logic [CFG_IDX_W-1:0] REG_STILL_THRESHOLD      = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_STILL_SAMPLES_NEEDED = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_GRAVITY_COUNTS       = 2'd2;

    localparam logic [THRESH_W-1:0] THRESH_RESET  = 16'd50;
    localparam logic [NEEDED_W-1:0] NEEDED_RESET  = 8'd200;
    localparam logic [GRAV_W-1:0]   GRAV_RESET    = 15'd16384;
    localparam logic [NEEDED_W-1:0] STILL_SAT     = 8'd255;

    typedef logic signed [SAMPLE_W-1:0] sample_t;

    typedef struct packed {
        logic track;
        logic acc;
        logic div_load;
        logic div_step;
        logic div_fix;
    } lane_ctrl_t;

endpackage

[rtl/imu_sbc_if.sv]
// Valid/ready channel interfaces for IMU sample and calibrated result words.
interface imu_sbc_sample_if;
    import imu_sbc_pkg::*;

    logic    valid;
    logic    ready;
    sample_t gyro_x;
    sample_t gyro_y;
    sample_t gyro_z;
    sample_t accel_x;
    sample_t accel_y;
    sample_t accel_z;

    modport source (output valid, gyro_x, gyro_y, gyro_z, accel_x, accel_y, accel_z,
                    input ready);
    modport sink   (input valid, gyro_x, gyro_y, gyro_z, accel_x, accel_y, accel_z,
                    output ready);
endinterface

interface imu_sbc_result_if;
    import imu_sbc_pkg::*;

    logic    valid;
    logic    ready;
    sample_t gyro_x_out;
    sample_t gyro_y_out;
    sample_t gyro_z_out;
    sample_t accel_x_out;
    sample_t accel_y_out;
    sample_t accel_z_out;

    modport source (output valid, gyro_x_out, gyro_y_out, gyro_z_out,
                    accel_x_out, accel_y_out, accel_z_out, input ready);
    modport sink   (input valid, gyro_x_out, gyro_y_out, gyro_z_out,
                    accel_x_out, accel_y_out, accel_z_out, output ready);
endinterface

[rtl/imu_sbc_lane.sv]
// One axis lane: gyro motion test, bias accumulation, reciprocal bias divide, correction.
module imu_sbc_lane #(
    parameter int GYRO    = 1,
    parameter int SUM_W   = 24,
    parameter int DIVISOR = 100,
    parameter int DIV_W   = 7
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  imu_sbc_pkg::lane_ctrl_t               ctrl,
    input  imu_sbc_pkg::sample_t                  sample,
    input  logic [imu_sbc_pkg::THRESH_W-1:0]      threshold,
    input  logic [imu_sbc_pkg::SAMPLE_W-1:0]      addend,
    output logic                                  moved,
    output imu_sbc_pkg::sample_t                  corrected
);
    import imu_sbc_pkg::*;

    // Sum magnitudes stay below 2**MAG_W, so ceil(2**SHIFT / DIVISOR) gives an exact quotient.
    localparam int MAG_W   = SUM_W - 1;
    localparam int SHIFT   = MAG_W + DIV_W;
    localparam int RECIP_W = SUM_W + 1;
    localparam int PROD_W  = MAG_W + RECIP_W;
    localparam longint unsigned RECIP_FULL =
        ((64'd1 << SHIFT) + 64'(DIVISOR) - 64'd1) / 64'(DIVISOR);
    localparam logic [RECIP_W-1:0] RECIP = RECIP_W'(RECIP_FULL);

    logic [SUM_W-1:0]  sum_reg;
    logic [SUM_W-1:0]  sum_next;
    logic              sign_reg;
    logic              sign_next;
    logic [PROD_W-1:0] product;
    logic [SUM_W-1:0]  sample_ext;

    generate
        if (GYRO != 0) begin : g_motion
            sample_t           prev_reg;
            logic [SAMPLE_W:0] diff;
            logic [SAMPLE_W:0] diff_mag;

            always_ff @(posedge clk or negedge rst_n)
            begin
                if (!rst_n)
                begin
                    prev_reg <= '0;
                end
                else if (ctrl.track)
                begin
                    prev_reg <= sample;
                end
            end

            always_comb
            begin
                diff     = {sample[SAMPLE_W-1], sample} - {prev_reg[SAMPLE_W-1], prev_reg};
                diff_mag = diff[SAMPLE_W] ? (~diff + 1'b1) : diff;
                moved    = diff_mag > {1'b0, threshold};
            end
        end
        else begin : g_no_motion
            assign moved = 1'b0;
        end
    endgenerate

    always_comb
    begin
        sample_ext = {{(SUM_W-SAMPLE_W){sample[SAMPLE_W-1]}}, sample};
        product    = sum_reg[MAG_W-1:0] * RECIP;
        sum_next   = sum_reg;
        sign_next  = sign_reg;
        if (ctrl.acc)
        begin
            sum_next = sum_reg + sample_ext;
        end
        else if (ctrl.div_load)
        begin
            sign_next = sum_reg[SUM_W-1];
            sum_next  = sum_reg[SUM_W-1] ? (~sum_reg + 1'b1) : sum_reg;
        end
        else if (ctrl.div_step)
        begin
            sum_next = SUM_W'(product >> SHIFT);
        end
        else if (ctrl.div_fix)
        begin
            sum_next = sign_reg ? (~sum_reg + 1'b1) : sum_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sum_reg  <= '0;
            sign_reg <= 1'b0;
        end
        else
        begin
            sum_reg  <= sum_next;
            sign_reg <= sign_next;
        end
    end

    assign corrected = sample - sum_reg[SAMPLE_W-1:0] + addend;

endmodule

[rtl/imu_still_bias_calibration.sv]
// Top level of the IMU still-bias calibration block: phase control and result buffer.
// Flow: one sample word is taken per clock while sample ready is high, and in the
// calibrated phase its corrected word is registered onto the result channel through a
// two-word output buffer so input keeps flowing while one result waits; sample ready
// drops when both buffer words are held. The sample that closes averaging starts a
// divide pass in all six lanes at once (take the magnitude, multiply by
// the reciprocal of AVERAGE_SAMPLES, restore the sign), with sample ready low for
// the whole pass. No result is given while waiting for stillness or averaging.
// Configuration writes act at once.
module imu_still_bias_calibration #(
    parameter int AVERAGE_SAMPLES = 100
) (
    input  logic                                   clk,
    input  logic                                   rst_n,
    imu_sbc_sample_if.sink                         sample,
    imu_sbc_result_if.source                       result,
    input  logic                                   cfg_we,
    input  logic [imu_sbc_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [imu_sbc_pkg::CFG_W-1:0]          cfg_data
);
    import imu_sbc_pkg::*;

    localparam int AVG_W      = $clog2(AVERAGE_SAMPLES + 1);
    localparam int SUM_W      = SAMPLE_W + AVG_W;
    localparam int DIV_CYCLES = 3;
    localparam int CNT_W      = $clog2(DIV_CYCLES);

    localparam logic [1:0] ST_WAIT = 2'd0;
    localparam logic [1:0] ST_AVG  = 2'd1;
    localparam logic [1:0] ST_DIV  = 2'd2;
    localparam logic [1:0] ST_CAL  = 2'd3;

    logic [1:0]              state_reg;
    logic [1:0]              state_next;
    logic [NEEDED_W-1:0]     still_reg;
    logic [NEEDED_W-1:0]     still_next;
    logic [AVG_W-1:0]        avg_cnt_reg;
    logic [AVG_W-1:0]        avg_cnt_next;
    logic [CNT_W-1:0]        div_cnt_reg;
    logic [CNT_W-1:0]        div_cnt_next;
    logic [THRESH_W-1:0]     threshold_reg;
    logic [NEEDED_W-1:0]     needed_reg;
    logic [GRAV_W-1:0]       gravity_reg;

    logic [NUM_AXES-1:0][SAMPLE_W-1:0] head_reg;
    logic [NUM_AXES-1:0][SAMPLE_W-1:0] skid_reg;
    logic                              head_valid_reg;
    logic                              skid_valid_reg;

    sample_t                           lane_in   [NUM_AXES];
    sample_t                           lane_out  [NUM_AXES];
    logic [NUM_AXES-1:0][SAMPLE_W-1:0] corrected;
    logic [NUM_AXES-1:0]               moved;
    lane_ctrl_t                        ctrl;
    logic                              accept;
    logic                              push;
    logic                              pop;

    assign lane_in[0] = sample.gyro_x;
    assign lane_in[1] = sample.gyro_y;
    assign lane_in[2] = sample.gyro_z;
    assign lane_in[3] = sample.accel_x;
    assign lane_in[4] = sample.accel_y;
    assign lane_in[5] = sample.accel_z;

    genvar gi;
    generate
        for (gi = 0; gi < NUM_AXES; gi++)
        begin : g_lane
            imu_sbc_lane #(
                .GYRO    ((gi < NUM_GYRO) ? 1 : 0),
                .SUM_W   (SUM_W),
                .DIVISOR (AVERAGE_SAMPLES),
                .DIV_W   (AVG_W)
            ) u_lane (
                .clk       (clk),
                .rst_n     (rst_n),
                .ctrl      (ctrl),
                .sample    (lane_in[gi]),
                .threshold (threshold_reg),
                .addend    ((gi == NUM_AXES - 1) ? {1'b0, gravity_reg} : '0),
                .moved     (moved[gi]),
                .corrected (lane_out[gi])
            );
            assign corrected[gi] = lane_out[gi];
        end
    endgenerate

    assign sample.ready = !skid_valid_reg && (state_reg != ST_DIV);
    assign accept       = sample.valid && sample.ready;
    assign pop          = head_valid_reg && result.ready;
    assign push         = accept && (state_reg == ST_CAL);

    always_comb
    begin
        state_next   = state_reg;
        still_next   = still_reg;
        avg_cnt_next = avg_cnt_reg;
        div_cnt_next = div_cnt_reg;
        ctrl         = '0;
        unique case (state_reg)
            ST_WAIT:
            begin
                if (accept)
                begin
                    ctrl.track = 1'b1;
                    if (|moved)
                    begin
                        still_next = '0;
                    end
                    else if (still_reg != STILL_SAT)
                    begin
                        still_next = still_reg + 1'b1;
                    end
                    if (still_next >= needed_reg)
                    begin
                        state_next = ST_AVG;
                    end
                end
            end
            ST_AVG:
            begin
                if (accept)
                begin
                    ctrl.acc     = 1'b1;
                    avg_cnt_next = avg_cnt_reg + 1'b1;
                    if (avg_cnt_next == AVG_W'(AVERAGE_SAMPLES))
                    begin
                        state_next   = ST_DIV;
                        div_cnt_next = '0;
                    end
                end
            end
            ST_DIV:
            begin
                div_cnt_next = div_cnt_reg + 1'b1;
                if (div_cnt_reg == '0)
                begin
                    ctrl.div_load = 1'b1;
                end
                else if (div_cnt_reg == CNT_W'(DIV_CYCLES - 1))
                begin
                    ctrl.div_fix = 1'b1;
                    state_next   = ST_CAL;
                end
                else
                begin
                    ctrl.div_step = 1'b1;
                end
            end
            ST_CAL:
            begin
                state_next = ST_CAL;
            end
            default:
            begin
                state_next = ST_WAIT;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_WAIT;
            still_reg   <= '0;
            avg_cnt_reg <= '0;
            div_cnt_reg <= '0;
        end
        else
        begin
            state_reg   <= state_next;
            still_reg   <= still_next;
            avg_cnt_reg <= avg_cnt_next;
            div_cnt_reg <= div_cnt_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            threshold_reg <= THRESH_RESET;
            needed_reg    <= NEEDED_RESET;
            gravity_reg   <= GRAV_RESET;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_STILL_THRESHOLD:      threshold_reg <= cfg_data[THRESH_W-1:0];
                REG_STILL_SAMPLES_NEEDED: needed_reg    <= cfg_data[NEEDED_W-1:0];
                REG_GRAVITY_COUNTS:       gravity_reg   <= cfg_data[GRAV_W-1:0];
                default:                  ;
            endcase
        end
    end

    // Two-word output buffer: head feeds the port, skid holds the overflow word.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_valid_reg <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else if (pop)
        begin
            head_valid_reg <= skid_valid_reg || push;
            skid_valid_reg <= 1'b0;
        end
        else if (push)
        begin
            head_valid_reg <= 1'b1;
            skid_valid_reg <= head_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            head_reg <= skid_valid_reg ? skid_reg : corrected;
        end
        else if (push && !head_valid_reg)
        begin
            head_reg <= corrected;
        end
        if (push && head_valid_reg && !pop)
        begin
            skid_reg <= corrected;
        end
    end

    assign result.valid       = head_valid_reg;
    assign result.gyro_x_out  = head_reg[0];
    assign result.gyro_y_out  = head_reg[1];
    assign result.gyro_z_out  = head_reg[2];
    assign result.accel_x_out = head_reg[3];
    assign result.accel_y_out = head_reg[4];
    assign result.accel_z_out = head_reg[5];

endmodule

[rtl/imu_sbc_checker.sv]
// Port-level checks for the IMU still-bias calibration block, bound to the top level.
module imu_sbc_checker (
    input logic                         clk,
    input logic                         rst_n,
    input logic                         in_valid,
    input logic                         in_ready,
    input logic                         out_valid,
    input logic                         out_ready,
    input logic [imu_sbc_pkg::SAMPLE_W-1:0] out_gx,
    input logic [imu_sbc_pkg::SAMPLE_W-1:0] out_az
);
    import imu_sbc_pkg::*;

    logic in_acc;
    logic seen_reg;

    assign in_acc = in_valid && in_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            seen_reg <= 1'b0;
        end
        else if (out_valid)
        begin
            seen_reg <= 1'b1;
        end
    end

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid)
        else $error("result word dropped while stalled");

    a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> $stable(out_gx) && $stable(out_az))
        else $error("stalled result word changed");

    a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
        !in_acc && !out_valid |=> !out_valid)
        else $error("result word without a sample word");

    a_cal_result: assert property (@(posedge clk) disable iff (!rst_n)
        seen_reg && in_acc && !out_valid |=> out_valid)
        else $error("calibrated sample word gave no result");

endmodule

bind imu_still_bias_calibration imu_sbc_checker u_imu_sbc_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (sample.valid),
    .in_ready  (sample.ready),
    .out_valid (result.valid),
    .out_ready (result.ready),
    .out_gx    (result.gyro_x_out),
    .out_az    (result.accel_z_out)
);
